// ----- src/box_blur_3x3_border_copy_macros.svh -----
// Assertion macros shared by the 3x3 box blur RTL.
`ifndef BOX_BLUR_3X3_BORDER_COPY_MACROS_SVH
`define BOX_BLUR_3X3_BORDER_COPY_MACROS_SVH

// Property checked on every rising clock edge outside of reset.
`define BB3_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Condition that must never be seen outside of reset.
`define BB3_ASSERT_NEVER(lbl, expr, msg) \
    `BB3_ASSERT(lbl, !(expr), msg)

`endif

// ----- src/bb3_pkg.sv -----
// Package for the 3x3 box blur: constants, command codes and stage structs.
`timescale 1ns / 1ps
`default_nettype none
package bb3_pkg;

    // Line store depth and derived column counter width
    localparam int MAX_WIDTH   = 1024;
    localparam int CNT_W       = $clog2(MAX_WIDTH);

    localparam int PIX_W       = 8;
    localparam int CFG_W       = 11;
    localparam int MAX_W       = 9;
    localparam int ROW_W       = 2;
    localparam int WIDTH_RESET = 640;

    // Nine 8-bit pixels sum to at most 2295
    localparam int SUM_W       = 12;

    // floor(s / 9) == (s * 7282) >> 16 for every s below 2296
    localparam int RECIP_9     = 7282;
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 16;
    localparam int PROD_W      = SUM_W + RECIP_W;

    // Result queue, depth must be a power of two
    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

    typedef enum logic {
        CMD_PIXEL = 1'b0,
        CMD_DRAIN = 1'b1
    } t_cmd;

    // Item after the transfer edge, line store read in flight
    typedef struct packed {
        logic              valid;
        logic              is_drain;
        logic [PIX_W-1:0]  pix;
        logic [CNT_W-1:0]  addr;
        logic              emit_a;
        logic              interior;
        logic              run_last_a;
        logic              emit_b;
        logic              image_last;
    } t_s1;

    // Item after the window stage
    typedef struct packed {
        logic              valid;
        logic [SUM_W-1:0]  sum;
        logic [PIX_W-1:0]  val_a;
        logic [PIX_W-1:0]  val_b;
        logic              emit_a;
        logic              interior;
        logic              run_last_a;
        logic              emit_b;
        logic              image_last;
    } t_s2;

    typedef struct packed {
        logic [PIX_W-1:0]        pixel_out;
        logic                    run_last;
        logic                    image_last;
        logic signed [MAX_W-1:0] interior_max;
    } t_result;

    // Up to two results written into the queue per cycle
    typedef struct packed {
        logic    push_a;
        logic    push_b;
        t_result res_a;
        t_result res_b;
    } t_push;

endpackage
`default_nettype wire

// ----- src/box_blur_3x3_border_copy.sv -----
// Top level of the 3x3 box blur with border copy.
// Pipeline: each item passes the stage-one register, the stage-two register and the
//   result queue; a second result (end of row) is written into the queue with the first.
// Throughput: one item per cycle; the input stalls only when the 8-entry result
//   queue plus the two items in flight could overflow it.
// Reset (synchronous, active low): width 640, counters zero, maximum -1, queue empty;
//   line stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "box_blur_3x3_border_copy_macros.svh"
module box_blur_3x3_border_copy
    import bb3_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [CFG_W-1:0]        i_cfg_image_width,
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire logic                    i_command,
    input  wire logic [PIX_W-1:0]        i_pixel_in,
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic [PIX_W-1:0]             o_pixel_out,
    output logic                         o_run_last,
    output logic                         o_image_last,
    output logic signed [MAX_W-1:0]      o_interior_max
);

    localparam int CRED_W = FIFO_AW + 2;

    logic               accept, pop;
    logic [CNT_W-1:0]   rd_addr;
    t_s1                s1;
    t_s2                s2;
    t_push              push;
    t_result            head;
    logic [FIFO_AW:0]   fifo_cnt;
    logic [CRED_W-1:0]  w_credit;

    assign o_cfg_ready = 1'b1;

    // Queue space held for every item in flight, two results each
    assign w_credit = CRED_W'(fifo_cnt) + (s1.valid ? CRED_W'(2) : '0)
                    + (s2.valid ? CRED_W'(2) : '0);
    assign o_stall  = (w_credit > CRED_W'(FIFO_DEPTH - 2));
    assign accept   = i_valid && !o_stall;

    bb3_ctrl u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_image_width (i_cfg_image_width),
        .i_accept          (accept),
        .i_command         (i_command),
        .i_pixel_in        (i_pixel_in),
        .o_rd_addr         (rd_addr),
        .o_s1              (s1)
    );

    bb3_window u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (rd_addr),
        .i_s1      (s1),
        .o_s2      (s2)
    );

    bb3_divmax u_divmax (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_s2    (s2),
        .o_push  (push)
    );

    bb3_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_count (fifo_cnt)
    );

    // Output transfer
    assign o_valid        = (fifo_cnt != '0);
    assign pop            = o_valid && !i_stall;
    assign o_pixel_out    = head.pixel_out;
    assign o_run_last     = head.run_last;
    assign o_image_last   = head.image_last;
    assign o_interior_max = head.interior_max;

    `BB3_ASSERT_NEVER(a_credit_bound, w_credit > CRED_W'(FIFO_DEPTH), "result queue credit exceeded")
    `BB3_ASSERT(a_image_last_ends_run, (o_valid && o_image_last) |-> o_run_last, "image end without run end")

endmodule
`default_nettype wire

// ----- src/bb3_ctrl.sv -----
// Width register, raster counters and per-item decisions at the transfer edge.
`timescale 1ns / 1ps
`default_nettype none
`include "box_blur_3x3_border_copy_macros.svh"
module bb3_ctrl
    import bb3_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_valid,
    input  wire logic [CFG_W-1:0] i_cfg_image_width,
    input  wire logic             i_accept,
    input  wire logic             i_command,
    input  wire logic [PIX_W-1:0] i_pixel_in,
    output logic      [CNT_W-1:0] o_rd_addr,
    output t_s1                   o_s1
);

    logic [CFG_W-1:0] r_width;
    logic [CNT_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [CNT_W-1:0] r_drain, n_drain;
    t_s1              r_s1, n_s1;

    logic [CNT_W-1:0] w_m1;
    logic             is_drain;
    logic             row_ge1, row_ge2, col_end;
    logic             drain_ok, drain_last, pixel_ok;

    // Clamp the width to 3..MAX_WIDTH, kept as width minus one
    always_comb begin
        if (r_width < CFG_W'(3)) begin
            w_m1 = CNT_W'(2);
        end else if (32'(r_width) > MAX_WIDTH) begin
            w_m1 = CNT_W'(MAX_WIDTH - 1);
        end else begin
            w_m1 = CNT_W'(r_width - CFG_W'(1));
        end
    end

    // Position decode
    assign is_drain   = (t_cmd'(i_command) == CMD_DRAIN);
    assign row_ge1    = (r_row != '0);
    assign row_ge2    = (r_row == ROW_W'(2));
    assign col_end    = (r_col >= w_m1);
    assign drain_ok   = row_ge1 && (r_col == '0);
    assign drain_last = (r_drain >= w_m1);
    assign pixel_ok   = (r_drain == '0);
    assign o_rd_addr  = is_drain ? r_drain : r_col;

    // Decide the results of this item and advance the counters
    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_drain = r_drain;
        n_s1    = '0;
        n_s1.is_drain = is_drain;
        n_s1.pix      = i_pixel_in;
        n_s1.addr     = o_rd_addr;
        if (is_drain) begin
            n_s1.valid      = drain_ok;
            n_s1.emit_a     = 1'b1;
            n_s1.run_last_a = 1'b1;
            n_s1.image_last = drain_last;
            if (drain_ok) begin
                if (drain_last) begin
                    n_drain = '0;
                    n_col   = '0;
                    n_row   = '0;
                end else begin
                    n_drain = r_drain + CNT_W'(1);
                end
            end
        end else begin
            n_s1.valid      = pixel_ok;
            n_s1.emit_a     = row_ge1 && (r_col != '0);
            n_s1.interior   = row_ge2 && (r_col >= CNT_W'(2)) && (r_col <= w_m1);
            n_s1.run_last_a = !col_end;
            n_s1.emit_b     = row_ge1 && col_end;
            if (pixel_ok) begin
                if (col_end) begin
                    n_col = '0;
                    if (r_row != ROW_W'(2)) begin
                        n_row = r_row + ROW_W'(1);
                    end
                end else begin
                    n_col = r_col + CNT_W'(1);
                end
            end
        end
    end

    // State and stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= CFG_W'(WIDTH_RESET);
            r_col   <= '0;
            r_row   <= '0;
            r_drain <= '0;
            r_s1    <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_width <= i_cfg_image_width;
            end
            if (i_accept) begin
                r_col   <= n_col;
                r_row   <= n_row;
                r_drain <= n_drain;
                r_s1    <= n_s1;
            end else begin
                r_s1.valid <= 1'b0;
            end
        end
    end

    assign o_s1 = r_s1;

    `BB3_ASSERT(a_drain_at_row_start, (r_drain != '0) |-> (r_col == '0 && r_row != '0), "drain count set outside a row start")
    `BB3_ASSERT(a_misplaced_drain_dropped, (i_accept && is_drain && r_col != '0) |=> !r_s1.valid, "drain in mid row was not dropped")

endmodule
`default_nettype wire

// ----- src/bb3_window.sv -----
// Line stores, 3x3 window and neighborhood sum.
`timescale 1ns / 1ps
`default_nettype none
module bb3_window
    import bb3_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_rd_en,
    input  wire logic [CNT_W-1:0] i_rd_addr,
    input  wire t_s1              i_s1,
    output t_s2                   o_s2
);

    logic [PIX_W-1:0] r_line_two [MAX_WIDTH];
    logic [PIX_W-1:0] r_line_one [MAX_WIDTH];
    logic [PIX_W-1:0] r_rd_two, r_rd_one;
    logic [PIX_W-1:0] r_win [9];
    logic [PIX_W-1:0] n_win [9];
    logic [SUM_W-1:0] row_sum [3];
    logic             shift_en;
    t_s2              r_s2;

    assign shift_en = i_s1.valid && !i_s1.is_drain;

    // Read at the transfer edge. The write made in the cycle after it always hits a
    // different column than the read of the item behind it.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_two <= r_line_two[i_rd_addr];
            r_rd_one <= r_line_one[i_rd_addr];
        end
    end

    // Push the column down: row one back moves to two back
    always_ff @(posedge i_clk) begin
        if (shift_en) begin
            r_line_two[i_s1.addr] <= r_rd_one;
            r_line_one[i_s1.addr] <= i_s1.pix;
        end
    end

    // Window shifts left, new right column from the stores and the pixel
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_win[k*3]     = r_win[k*3+1];
            n_win[k*3 + 1] = r_win[k*3+2];
        end
        n_win[2] = r_rd_two;
        n_win[5] = r_rd_one;
        n_win[8] = i_s1.pix;
    end

    // Sum as row sums then total
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            row_sum[k] = SUM_W'(n_win[k*3]) + SUM_W'(n_win[k*3+1]) + SUM_W'(n_win[k*3+2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= '0;
            end
        end else if (shift_en) begin
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= n_win[k];
            end
        end
    end

    // Stage register; border value is the old window center-right, or the line store read for a drain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
        end else begin
            r_s2.valid <= i_s1.valid;
        end
        r_s2.sum        <= row_sum[0] + row_sum[1] + row_sum[2];
        r_s2.val_a      <= i_s1.is_drain ? r_rd_one : r_win[5];
        r_s2.val_b      <= r_rd_one;
        r_s2.emit_a     <= i_s1.emit_a;
        r_s2.interior   <= i_s1.interior;
        r_s2.run_last_a <= i_s1.run_last_a;
        r_s2.emit_b     <= i_s1.emit_b;
        r_s2.image_last <= i_s1.image_last;
    end

    assign o_s2 = r_s2;

endmodule
`default_nettype wire

// ----- src/bb3_divmax.sv -----
// Divide by nine, running interior maximum and result formatting.
`timescale 1ns / 1ps
`default_nettype none
module bb3_divmax
    import bb3_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_s2  i_s2,
    output t_push     o_push
);

    logic signed [MAX_W-1:0] r_max, max_new, cand;
    logic [PROD_W-1:0]       prod;
    logic [PIX_W-1:0]        quot;
    t_result                 res_1, res_2;

    // Reciprocal multiply
    assign prod = PROD_W'(i_s2.sum) * PROD_W'(RECIP_9);
    assign quot = prod[RECIP_SHIFT +: PIX_W];
    assign cand = signed'({1'b0, quot});

    // Maximum including this item
    always_comb begin
        max_new = r_max;
        if (i_s2.valid && i_s2.interior && (cand > r_max)) begin
            max_new = cand;
        end
    end

    // Final drain starts the next image with no maximum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= '1;
        end else if (i_s2.valid) begin
            if (i_s2.image_last) begin
                r_max <= '1;
            end else begin
                r_max <= max_new;
            end
        end
    end

    // Filtered or copied pixel, then the end-of-row copy
    always_comb begin
        res_1.pixel_out    = i_s2.interior ? quot : i_s2.val_a;
        res_1.run_last     = i_s2.run_last_a;
        res_1.image_last   = i_s2.image_last;
        res_1.interior_max = max_new;
        res_2.pixel_out    = i_s2.val_b;
        res_2.run_last     = 1'b1;
        res_2.image_last   = 1'b0;
        res_2.interior_max = max_new;
    end

    assign o_push.push_a = i_s2.valid && (i_s2.emit_a || i_s2.emit_b);
    assign o_push.push_b = i_s2.valid && i_s2.emit_a && i_s2.emit_b;
    assign o_push.res_a  = i_s2.emit_a ? res_1 : res_2;
    assign o_push.res_b  = res_2;

endmodule
`default_nettype wire

// ----- src/bb3_out_fifo.sv -----
// Result queue: two writes and one read per cycle.
`timescale 1ns / 1ps
`default_nettype none
module bb3_out_fifo
    import bb3_pkg::*;
(
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire t_push          i_push,
    input  wire logic           i_pop,
    output t_result             o_head,
    output logic  [FIFO_AW:0]   o_count
);

    localparam int CW = FIFO_AW + 1;

    t_result            r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr, r_rd;
    logic [CW-1:0]      r_cnt;
    logic [CW-1:0]      n_push;

    assign n_push = CW'(i_push.push_a) + CW'(i_push.push_b);

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push.push_a) begin
            r_mem[r_wr] <= i_push.res_a;
        end
        if (i_push.push_b) begin
            r_mem[r_wr + FIFO_AW'(1)] <= i_push.res_b;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + FIFO_AW'(n_push);
            r_rd  <= r_rd + FIFO_AW'(i_pop);
            r_cnt <= r_cnt + n_push - CW'(i_pop);
        end
    end

    assign o_head  = r_mem[r_rd];
    assign o_count = r_cnt;

endmodule
`default_nettype wire
